FILE: rtl/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared widths, plane tables and matrix helpers for sphere versus
// projection-volume culling.
// ----------------------------------------------------------------------------
package sfc_pkg;

    localparam int NUM_PLANES   = 5;
    localparam int NUM_CFG_REGS = 8;
    localparam int REG_IDX_W    = 3;
    localparam int CFG_ADDR_W   = 4;
    localparam int CFG_W        = 64;
    localparam int MAT_W        = 32;

    localparam int COORD_W      = 32;
    localparam int RAD_W        = 31;
    localparam int IN_TDATA_W   = 128;
    localparam int OUT_TDATA_W  = 8;

    // plane coefficients are a sum or difference of two matrix entries
    localparam int NRM_W        = MAT_W + 1;
    localparam int SQ_W         = 2 * NRM_W - 1;
    localparam int NN_W         = SQ_W + 1;
    localparam int R2_W         = 2 * RAD_W;

    // split points for the r^2 * |n|^2 partial products
    localparam int RL_W         = 31;
    localparam int NL_W         = 33;

    // pipeline stages: input, products, dot, magnitude, partials, compare
    localparam int NUM_STAGES   = 6;
    localparam int ST_IN        = 0;
    localparam int ST_PROD      = 1;
    localparam int ST_DOT       = 2;
    localparam int ST_MAG       = 3;
    localparam int ST_PART      = 4;
    localparam int ST_CMP       = 5;

    // left, right, bottom, top, far
    localparam int unsigned PLANE_ROW [NUM_PLANES] = '{0, 0, 1, 1, 2};
    localparam bit          PLANE_ADD [NUM_PLANES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0};

    typedef logic [NUM_CFG_REGS-1:0][CFG_W-1:0] t_mat_regs;

    typedef struct packed {
        logic signed [NRM_W-1:0] n0;
        logic signed [NRM_W-1:0] n1;
        logic signed [NRM_W-1:0] n2;
        logic signed [NRM_W-1:0] w;
    } t_plane;

    typedef t_plane [NUM_PLANES-1:0] t_plane_set;

    function automatic logic signed [MAT_W-1:0] mat_entry(
        input t_mat_regs   m,
        input int unsigned row,
        input int unsigned col
    );
        logic [CFG_W-1:0] word_v;
        word_v = m[REG_IDX_W'(2 * col + (row >> 1))];
        return row[0] ? $signed(word_v[CFG_W-1:MAT_W]) : $signed(word_v[MAT_W-1:0]);
    endfunction

    // row 3 plus or minus the plane's row, one column
    function automatic logic signed [NRM_W-1:0] plane_coef(
        input t_mat_regs   m,
        input int unsigned p,
        input int unsigned col
    );
        logic signed [NRM_W-1:0] a;
        logic signed [NRM_W-1:0] b;
        a = NRM_W'(mat_entry(m, 3, col));
        b = NRM_W'(mat_entry(m, PLANE_ROW[p], col));
        return PLANE_ADD[p] ? a + b : a - b;
    endfunction

endpackage

FILE: rtl/sfc_cfg_planes.sv
// ----------------------------------------------------------------------------
// sfc_cfg_planes
// Matrix registers and the plane terms derived from them: normals, offsets,
// nonzero flags and squared normal lengths.
// ----------------------------------------------------------------------------
module sfc_cfg_planes #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_cfg_valid,
    output logic                                         o_cfg_ready,
    input  logic [sfc_pkg::CFG_ADDR_W-1:0]               i_cfg_addr,
    input  logic [sfc_pkg::CFG_W-1:0]                    i_cfg_data,
    output sfc_pkg::t_plane_set                          o_plane,
    output logic [sfc_pkg::NUM_PLANES-1:0]               o_nonzero,
    output logic [sfc_pkg::NUM_PLANES-1:0][sfc_pkg::NN_W-1:0] o_nn
);

    localparam logic [sfc_pkg::CFG_W-1:0] ONE_LO = sfc_pkg::CFG_W'(1) << FRAC_BITS;
    localparam logic [sfc_pkg::CFG_W-1:0] ONE_HI = ONE_LO << sfc_pkg::MAT_W;
    localparam logic [sfc_pkg::CFG_W-1:0] ZERO_W = '0;
    // identity matrix, register 7 first
    localparam sfc_pkg::t_mat_regs MAT_RESET = {ONE_HI, ZERO_W, ONE_LO, ZERO_W,
                                                ZERO_W, ONE_HI, ZERO_W, ONE_LO};

    sfc_pkg::t_mat_regs                           r_mat;
    sfc_pkg::t_plane_set                          r_plane;
    sfc_pkg::t_plane_set                          n_plane;
    logic [sfc_pkg::NUM_PLANES-1:0]               r_nonzero;
    logic [sfc_pkg::NUM_PLANES-1:0]               n_nonzero;
    logic [sfc_pkg::NUM_PLANES-1:0][2:0][sfc_pkg::SQ_W-1:0] r_sq;
    logic [sfc_pkg::NUM_PLANES-1:0][2:0][sfc_pkg::SQ_W-1:0] n_sq;
    logic [sfc_pkg::NUM_PLANES-1:0][sfc_pkg::NN_W-1:0]      r_nn;
    logic [sfc_pkg::NUM_PLANES-1:0][sfc_pkg::NN_W-1:0]      n_nn;
    logic signed [2*sfc_pkg::NRM_W-1:0]           sq0 [sfc_pkg::NUM_PLANES];
    logic signed [2*sfc_pkg::NRM_W-1:0]           sq1 [sfc_pkg::NUM_PLANES];
    logic signed [2*sfc_pkg::NRM_W-1:0]           sq2 [sfc_pkg::NUM_PLANES];

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat <= MAT_RESET;
        end else if (i_cfg_valid &&
                     i_cfg_addr < sfc_pkg::CFG_ADDR_W'(sfc_pkg::NUM_CFG_REGS)) begin
            r_mat[i_cfg_addr[sfc_pkg::REG_IDX_W-1:0]] <= i_cfg_data;
        end
    end

    // plane terms are registered from the matrix, squares from the registered
    // plane terms, and lengths from the registered squares
    always_comb begin
        for (int p = 0; p < sfc_pkg::NUM_PLANES; p++) begin
            n_plane[p].n0 = sfc_pkg::plane_coef(r_mat, p, 0);
            n_plane[p].n1 = sfc_pkg::plane_coef(r_mat, p, 1);
            n_plane[p].n2 = sfc_pkg::plane_coef(r_mat, p, 2);
            n_plane[p].w  = sfc_pkg::plane_coef(r_mat, p, 3);
            n_nonzero[p]  = (n_plane[p].n0 != '0) || (n_plane[p].n1 != '0) ||
                            (n_plane[p].n2 != '0);
            sq0[p]        = r_plane[p].n0 * r_plane[p].n0;
            sq1[p]        = r_plane[p].n1 * r_plane[p].n1;
            sq2[p]        = r_plane[p].n2 * r_plane[p].n2;
            n_sq[p][0]    = sq0[p][sfc_pkg::SQ_W-1:0];
            n_sq[p][1]    = sq1[p][sfc_pkg::SQ_W-1:0];
            n_sq[p][2]    = sq2[p][sfc_pkg::SQ_W-1:0];
            n_nn[p]       = sfc_pkg::NN_W'(r_sq[p][0]) + sfc_pkg::NN_W'(r_sq[p][1]) +
                            sfc_pkg::NN_W'(r_sq[p][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_plane   <= n_plane;
        r_nonzero <= n_nonzero;
        r_sq      <= n_sq;
        r_nn      <= n_nn;
    end

    assign o_plane   = r_plane;
    assign o_nonzero = r_nonzero;
    assign o_nn      = r_nn;

endmodule

FILE: rtl/sfc_plane_test.sv
// ----------------------------------------------------------------------------
// sfc_plane_test
// One clip plane: signed distance, then d^2 against r^2*|n|^2 built from
// partial products, ending in a registered cull flag.
// ----------------------------------------------------------------------------
module sfc_plane_test #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic [sfc_pkg::NUM_STAGES-1:1]         i_en,
    input  logic signed [sfc_pkg::COORD_W-1:0]     i_cx,
    input  logic signed [sfc_pkg::COORD_W-1:0]     i_cy,
    input  logic signed [sfc_pkg::COORD_W-1:0]     i_cz,
    input  logic [sfc_pkg::R2_W-1:0]               i_r2,
    input  sfc_pkg::t_plane                        i_plane,
    input  logic                                   i_nonzero,
    input  logic [sfc_pkg::NN_W-1:0]               i_nn,
    output logic                                   o_cull
);

    localparam int PROD_W = sfc_pkg::NRM_W + sfc_pkg::COORD_W;
    localparam int WSH_W  = sfc_pkg::NRM_W + FRAC_BITS;
    localparam int SUM_W  = PROD_W + 2;
    localparam int DOT_W  = ((SUM_W > WSH_W) ? SUM_W : WSH_W) + 1;
    localparam int DMAG_W = DOT_W - 1;
    localparam int DL_W   = (DMAG_W + 1) / 2;
    localparam int DH_W   = DMAG_W - DL_W;
    localparam int D2_W   = 2 * DMAG_W;
    localparam int RL_W   = sfc_pkg::RL_W;
    localparam int RH_W   = sfc_pkg::R2_W - RL_W;
    localparam int NL_W   = sfc_pkg::NL_W;
    localparam int NH_W   = sfc_pkg::NN_W - NL_W;
    localparam int RHS_W  = sfc_pkg::R2_W + sfc_pkg::NN_W;
    localparam int CMP_W  = (D2_W > RHS_W) ? D2_W : RHS_W;

    logic signed [PROD_W-1:0]  r_p0;
    logic signed [PROD_W-1:0]  r_p1;
    logic signed [PROD_W-1:0]  r_p2;
    logic signed [DOT_W-1:0]   r_dot;
    logic signed [DOT_W-1:0]   n_dneg;
    logic [DMAG_W-1:0]         r_dmag;
    logic                      r3_neg;
    logic [RL_W+NL_W-1:0]      r_rp_ll;
    logic [RL_W+NH_W-1:0]      r_rp_lh;
    logic [RH_W+NL_W-1:0]      r_rp_hl;
    logic [RH_W+NH_W-1:0]      r_rp_hh;
    logic [RHS_W-1:0]          r_rhs;
    logic [2*DL_W-1:0]         r_dll;
    logic [DL_W+DH_W-1:0]      r_dlh;
    logic [2*DH_W-1:0]         r_dhh;
    logic                      r4_neg;
    logic [CMP_W-1:0]          n_d2;
    logic                      r_cull;

    assign n_dneg = -r_dot;
    assign n_d2   = (CMP_W'(r_dhh) << (2 * DL_W)) + (CMP_W'(r_dlh) << (DL_W + 1)) +
                    CMP_W'(r_dll);

    always_ff @(posedge i_clk) begin
        if (i_en[sfc_pkg::ST_PROD]) begin
            r_p0 <= i_plane.n0 * i_cx;
            r_p1 <= i_plane.n1 * i_cy;
            r_p2 <= i_plane.n2 * i_cz;
        end
        if (i_en[sfc_pkg::ST_DOT]) begin
            r_dot <= DOT_W'(r_p0) + DOT_W'(r_p1) + DOT_W'(r_p2) +
                     (DOT_W'(i_plane.w) <<< FRAC_BITS);
        end
        if (i_en[sfc_pkg::ST_MAG]) begin
            r3_neg  <= r_dot[DOT_W-1];
            r_dmag  <= n_dneg[DMAG_W-1:0];
            r_rp_ll <= i_r2[RL_W-1:0] * i_nn[NL_W-1:0];
            r_rp_lh <= i_r2[RL_W-1:0] * i_nn[sfc_pkg::NN_W-1:NL_W];
            r_rp_hl <= i_r2[sfc_pkg::R2_W-1:RL_W] * i_nn[NL_W-1:0];
            r_rp_hh <= i_r2[sfc_pkg::R2_W-1:RL_W] * i_nn[sfc_pkg::NN_W-1:NL_W];
        end
        if (i_en[sfc_pkg::ST_PART]) begin
            r4_neg <= r3_neg;
            r_dll  <= r_dmag[DL_W-1:0] * r_dmag[DL_W-1:0];
            r_dlh  <= r_dmag[DL_W-1:0] * r_dmag[DMAG_W-1:DL_W];
            r_dhh  <= r_dmag[DMAG_W-1:DL_W] * r_dmag[DMAG_W-1:DL_W];
            r_rhs  <= (RHS_W'(r_rp_hh) << (RL_W + NL_W)) + (RHS_W'(r_rp_lh) << NL_W) +
                      (RHS_W'(r_rp_hl) << RL_W) + RHS_W'(r_rp_ll);
        end
        // touching (d^2 equal) is kept, a zero normal never culls
        if (i_en[sfc_pkg::ST_CMP]) begin
            r_cull <= r4_neg && i_nonzero && (n_d2 > CMP_W'(r_rhs));
        end
    end

    assign o_cull = r_cull;

endmodule

FILE: rtl/sphere_frustum_cull.sv
// ----------------------------------------------------------------------------
// sphere_frustum_cull
// Tests one bounding sphere per item against five clip planes taken from a
// 4x4 fixed-point projection matrix held in configuration registers.
// ----------------------------------------------------------------------------
// pipeline: input acceptance reaches o_m_tvalid through six register stages
// throughput: one item per clock absent backpressure; each stage holds its item only while the
//   next stage is full and stalled, so bubbles close up under backpressure
// reset: clears all stage valids, loads the identity matrix, ready is low
//   while i_rst_n is low; derived plane terms follow through their registers
module sphere_frustum_cull #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // center_x [31:0], center_y [63:32], center_z [95:64], sphere_radius [126:96]
    input  logic [sfc_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // intersects [0]
    output logic [sfc_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sfc_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [sfc_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int CW = sfc_pkg::COORD_W;

    sfc_pkg::t_plane_set                                  plane;
    logic [sfc_pkg::NUM_PLANES-1:0]                       nonzero;
    logic [sfc_pkg::NUM_PLANES-1:0][sfc_pkg::NN_W-1:0]    nn;
    logic [sfc_pkg::NUM_PLANES-1:0]                       cull;

    logic [sfc_pkg::NUM_STAGES-1:0]  r_vld;
    logic [sfc_pkg::NUM_STAGES-1:0]  en;
    logic signed [CW-1:0]            r_cx;
    logic signed [CW-1:0]            r_cy;
    logic signed [CW-1:0]            r_cz;
    logic [sfc_pkg::RAD_W-1:0]       r_rad;
    logic [sfc_pkg::R2_W-1:0]        r1_r2;
    logic [sfc_pkg::R2_W-1:0]        r2_r2;

    sfc_cfg_planes #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_plane     (plane),
        .o_nonzero   (nonzero),
        .o_nn        (nn)
    );

    // a stage loads when empty or when the stage after it moves on
    always_comb begin
        en[sfc_pkg::NUM_STAGES-1] = !r_vld[sfc_pkg::NUM_STAGES-1] || i_m_tready;
        for (int k = sfc_pkg::NUM_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_s_tready = en[sfc_pkg::ST_IN] && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[sfc_pkg::ST_IN]) begin
                r_vld[sfc_pkg::ST_IN] <= i_s_tvalid;
            end
            for (int k = 1; k < sfc_pkg::NUM_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[sfc_pkg::ST_IN]) begin
            r_cx  <= i_s_tdata[CW-1:0];
            r_cy  <= i_s_tdata[2*CW-1:CW];
            r_cz  <= i_s_tdata[3*CW-1:2*CW];
            r_rad <= i_s_tdata[3*CW+sfc_pkg::RAD_W-1:3*CW];
        end
        if (en[sfc_pkg::ST_PROD]) begin
            r1_r2 <= r_rad * r_rad;
        end
        if (en[sfc_pkg::ST_DOT]) begin
            r2_r2 <= r1_r2;
        end
    end

    for (genvar p = 0; p < sfc_pkg::NUM_PLANES; p++) begin : g_plane
        sfc_plane_test #(
            .FRAC_BITS (FRAC_BITS)
        ) u_test (
            .i_clk     (i_clk),
            .i_en      (en[sfc_pkg::NUM_STAGES-1:1]),
            .i_cx      (r_cx),
            .i_cy      (r_cy),
            .i_cz      (r_cz),
            .i_r2      (r2_r2),
            .i_plane   (plane[p]),
            .i_nonzero (nonzero[p]),
            .i_nn      (nn[p]),
            .o_cull    (cull[p])
        );
    end

    assign o_m_tvalid = r_vld[sfc_pkg::NUM_STAGES-1];
    assign o_m_tdata  = {(sfc_pkg::OUT_TDATA_W - 1)'(0), ~|cull};

endmodule
